>>> sv/psd_pkg.sv
// Shared widths for the point to segment distance pipeline.
// No dependencies; every other file imports this package.
package psd_pkg;

   localparam int CoordW = 24;   // signed Q15.8 coordinate
   localparam int DiffW  = 25;   // coordinate difference
   localparam int ProdW  = 50;   // product of two differences, and its sums
   localparam int HalfW  = 25;   // half of the cross magnitude for the squaring
   localparam int DvdW   = 100;  // dividend of the squared-distance divide
   localparam int QuoW   = 50;   // quotient and squared distance
   localparam int DistW  = 25;   // root and result
   localparam int RemW   = 27;   // partial remainder of the root

endpackage

>>> sv/psd_front.sv
// Geometry front end: differences, products, case selection and squaring.
// Depends on psd_pkg. Six register stages; hands dividend and divisor on.
module psd_front
   import psd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic signed [CoordW-1:0] point_x,
   input  logic signed [CoordW-1:0] point_y,
   input  logic signed [CoordW-1:0] start_x,
   input  logic signed [CoordW-1:0] start_y,
   input  logic signed [CoordW-1:0] end_x,
   input  logic signed [CoordW-1:0] end_y,
   output logic                     out_valid,
   output logic [DvdW-1:0]          dividend,
   output logic [QuoW-1:0]          divisor
);

   logic                    a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff;
   logic                    f_valid_ff;
   logic signed [DiffW-1:0] dx_ff, dy_ff, vx_ff, vy_ff, wx_ff, wy_ff;
   logic signed [ProdW-1:0] dxdx_ff, dydy_ff, vxdx_ff, vydy_ff, vxvx_ff, vyvy_ff;
   logic signed [ProdW-1:0] wxwx_ff, wywy_ff, dyvx_ff, dxvy_ff;
   logic signed [ProdW-1:0] len2_ff, dot_ff, dv2_ff, dw2_ff, cross_ff;
   logic                    d_perp_in, d_perp_ff, e_perp_ff;
   logic [QuoW-1:0]         d_divisor_in, d_divisor_ff, e_divisor_ff, f_divisor_ff;
   logic [QuoW-1:0]         d_direct_in, d_direct_ff, e_direct_ff;
   logic [ProdW-1:0]        cmag_in, cmag_ff;
   logic [ProdW-1:0]        pll_ff, plh_ff, phh_ff;
   logic [DvdW-1:0]         dividend_in, dividend_ff;

   // case selection on the sums
   always_comb begin
      logic before_start;
      before_start = (len2_ff == '0) || (dot_ff <= 0);
      d_perp_in    = !before_start && (dot_ff < len2_ff);
      d_divisor_in = d_perp_in ? QuoW'(len2_ff) : QuoW'(1);
      d_direct_in  = before_start ? QuoW'(dv2_ff) : QuoW'(dw2_ff);
      cmag_in      = cross_ff < 0 ? ProdW'(-cross_ff) : ProdW'(cross_ff);
   end

   // squared cross from three partial products; plain cases pass through a divide by one
   always_comb begin
      if (e_perp_ff) begin
         dividend_in = {phh_ff, {QuoW{1'b0}}} + ({{QuoW{1'b0}}, plh_ff} << (HalfW + 1))
                       + {{QuoW{1'b0}}, pll_ff};
      end else begin
         dividend_in = {{QuoW{1'b0}}, e_direct_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff <= DiffW'(end_x) - DiffW'(start_x);
         dy_ff <= DiffW'(end_y) - DiffW'(start_y);
         vx_ff <= DiffW'(point_x) - DiffW'(start_x);
         vy_ff <= DiffW'(point_y) - DiffW'(start_y);
         wx_ff <= DiffW'(point_x) - DiffW'(end_x);
         wy_ff <= DiffW'(point_y) - DiffW'(end_y);

         dxdx_ff <= dx_ff * dx_ff;
         dydy_ff <= dy_ff * dy_ff;
         vxdx_ff <= vx_ff * dx_ff;
         vydy_ff <= vy_ff * dy_ff;
         vxvx_ff <= vx_ff * vx_ff;
         vyvy_ff <= vy_ff * vy_ff;
         wxwx_ff <= wx_ff * wx_ff;
         wywy_ff <= wy_ff * wy_ff;
         dyvx_ff <= dy_ff * vx_ff;
         dxvy_ff <= dx_ff * vy_ff;

         len2_ff  <= dxdx_ff + dydy_ff;
         dot_ff   <= vxdx_ff + vydy_ff;
         dv2_ff   <= vxvx_ff + vyvy_ff;
         dw2_ff   <= wxwx_ff + wywy_ff;
         cross_ff <= dyvx_ff - dxvy_ff;

         d_perp_ff    <= d_perp_in;
         d_divisor_ff <= d_divisor_in;
         d_direct_ff  <= d_direct_in;
         cmag_ff      <= cmag_in;

         e_perp_ff    <= d_perp_ff;
         e_divisor_ff <= d_divisor_ff;
         e_direct_ff  <= d_direct_ff;
         pll_ff <= ProdW'(cmag_ff[HalfW-1:0]) * ProdW'(cmag_ff[HalfW-1:0]);
         plh_ff <= ProdW'(cmag_ff[HalfW-1:0]) * ProdW'(cmag_ff[ProdW-1:HalfW]);
         phh_ff <= ProdW'(cmag_ff[ProdW-1:HalfW]) * ProdW'(cmag_ff[ProdW-1:HalfW]);

         dividend_ff  <= dividend_in;
         f_divisor_ff <= e_divisor_ff;
      end
   end

   assign out_valid = f_valid_ff;
   assign dividend  = dividend_ff;
   assign divisor   = f_divisor_ff;

endmodule

>>> sv/psd_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on psd_pkg. The quotient is known to fit QuoW bits.
module psd_divider
   import psd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [DvdW-1:0]  dividend,
   input  logic [QuoW-1:0]  divisor,
   output logic             out_valid,
   output logic [QuoW-1:0]  quotient
);

   logic            valid_ff [QuoW+1];
   logic [QuoW-1:0] rem_ff   [QuoW+1];
   logic [QuoW-1:0] lq_ff    [QuoW+1];
   logic [QuoW-1:0] den_ff   [QuoW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= dividend[DvdW-1:QuoW];
         lq_ff[0]  <= dividend[QuoW-1:0];
         den_ff[0] <= divisor;
      end
   end

   for (genvar i = 0; i < QuoW; i++) begin : g_step
      logic [QuoW:0]   trial;
      logic            qbit;
      logic [QuoW-1:0] rem_in;

      // shift in the next dividend bit, subtract where it fits
      always_comb begin
         trial  = {rem_ff[i], lq_ff[i][QuoW-1]};
         qbit   = trial >= {1'b0, den_ff[i]};
         rem_in = qbit ? QuoW'(trial - {1'b0, den_ff[i]}) : trial[QuoW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i+1] <= rem_in;
            lq_ff[i+1]  <= {lq_ff[i][QuoW-2:0], qbit};
            den_ff[i+1] <= den_ff[i];
         end
      end
   end

   assign out_valid = valid_ff[QuoW];
   assign quotient  = lq_ff[QuoW];

endmodule

>>> sv/psd_sqrt.sv
// Pipelined integer square root, one root bit per stage, rounded down.
// Depends on psd_pkg.
module psd_sqrt
   import psd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [QuoW-1:0]  radicand,
   output logic             out_valid,
   output logic [DistW-1:0] root
);

   logic             valid_ff [DistW+1];
   logic [QuoW-1:0]  nb_ff    [DistW+1];
   logic [RemW-1:0]  rem_ff   [DistW+1];
   logic [DistW-1:0] root_ff  [DistW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         nb_ff[0]   <= radicand;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < DistW; i++) begin : g_step
      logic [RemW+1:0] rr;
      logic [RemW+1:0] trial;
      logic            fits;

      // bring down two bits, try root*4+1
      always_comb begin
         rr    = {rem_ff[i], nb_ff[i][QuoW-1:QuoW-2]};
         trial = {{(RemW-DistW){1'b0}}, root_ff[i], 2'b01};
         fits  = rr >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            nb_ff[i+1]   <= {nb_ff[i][QuoW-3:0], 2'b00};
            rem_ff[i+1]  <= fits ? RemW'(rr - trial) : RemW'(rr);
            root_ff[i+1] <= {root_ff[i][DistW-2:0], fits};
         end
      end
   end

   assign out_valid = valid_ff[DistW];
   assign root      = root_ff[DistW];

endmodule

>>> sv/point_segment_distance.sv
// Top level of the point to segment distance pipeline.
// Depends on psd_pkg, psd_front, psd_divider and psd_sqrt.
//
//   channel | ports                       | word
//   req     | req_valid, req_stall        | point, segment start and end, Q15.8
//   rsp     | rsp_valid, rsp_stall        | distance, unsigned Q.8
//
// One word enters per cycle unless the pipeline holds; the path runs through 6
// front stages, 51 divider stages with its input register, 26 root stages with
// its input register, and the output register. The divider is the deepest part.
// Synchronous reset clears the valid bits only. The whole pipeline holds while a
// finished word waits at a stalled output; an empty last root slot still lets words in.
module point_segment_distance
   import psd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [CoordW-1:0] req_point_x,
   input  logic signed [CoordW-1:0] req_point_y,
   input  logic signed [CoordW-1:0] req_start_x,
   input  logic signed [CoordW-1:0] req_start_y,
   input  logic signed [CoordW-1:0] req_end_x,
   input  logic signed [CoordW-1:0] req_end_y,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [DistW-1:0]         rsp_distance
);

   logic             advance;
   logic             out_free;
   logic             front_valid, div_valid, root_valid;
   logic [DvdW-1:0]  dividend;
   logic [QuoW-1:0]  divisor, quotient;
   logic [DistW-1:0] root;
   logic             rsp_valid_ff;
   logic [DistW-1:0] distance_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // hold only when a word at the tail has nowhere to go
   assign advance   = !root_valid || out_free;
   assign req_stall = !advance;

   psd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .point_x   (req_point_x),
      .point_y   (req_point_y),
      .start_x   (req_start_x),
      .start_y   (req_start_y),
      .end_x     (req_end_x),
      .end_y     (req_end_y),
      .out_valid (front_valid),
      .dividend  (dividend),
      .divisor   (divisor)
   );

   psd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .dividend  (dividend),
      .divisor   (divisor),
      .out_valid (div_valid),
      .quotient  (quotient)
   );

   psd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (div_valid),
      .radicand  (quotient),
      .out_valid (root_valid),
      .root      (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= root_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         distance_ff <= root;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = distance_ff;

endmodule
